### hdl/pgm_pkg.sv
// Shared types and constants for the pan/gain mix accumulator.
// No dependencies; every other file of the block refers to this package.
package pgm_pkg;

  // default sizes handed to the top level parameters
  localparam int unsigned FRAMES_DEF    = 4096;
  localparam int unsigned PAN_STEPS_DEF = 256;

  // field widths
  localparam int unsigned IDX_W      = 12;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned VOL_W      = 16;
  localparam int unsigned GAIN_W     = 15;               // Q1.14, 0..16384
  localparam int unsigned VG_W       = VOL_W + GAIN_W;   // volume * gain
  localparam int unsigned PROD_W     = SAMPLE_W + VG_W;  // sample * volume * gain
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // fixed-point reference points
  localparam int unsigned VOL_UNITY = 16384;
  localparam int unsigned PAN_FULL  = 16384;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VOLUME = 2'd0,
    CFG_PAN    = 2'd1,
    CFG_STEREO = 2'd2
  } cfg_reg_e;

  // item opcodes
  typedef enum logic {
    OP_ACCUM = 1'b0,
    OP_READ  = 1'b1
  } opcode_e;

  // input transaction payload
  typedef struct packed {
    opcode_e                    opcode;
    logic [IDX_W-1:0]           frame_index;
    logic signed [SAMPLE_W-1:0] sample_left;
    logic signed [SAMPLE_W-1:0] sample_right;
  } in_item_t;

  // output transaction payload
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sum_left;
    logic signed [SAMPLE_W-1:0] sum_right;
  } out_item_t;

  // classified command passed from front to back through the queue
  typedef struct packed {
    opcode_e                    opcode;
    logic                       in_range;
    logic [IDX_W-1:0]           frame_index;
    logic signed [SAMPLE_W-1:0] sample_left;
    logic signed [SAMPLE_W-1:0] sample_right;  // already mono-resolved
  } cmd_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

  // combined volume * pan gain per side
  typedef struct packed {
    logic [VG_W-1:0] vg_left;
    logic [VG_W-1:0] vg_right;
  } gain_t;

endpackage

### hdl/pgm_front.sv
// Front end: configuration registers, pan gain table, input classification.
// Depends on pgm_pkg; feeds pgm_queue and hands the track gains to pgm_back.
module pgm_front #(
  parameter int unsigned FRAMES    = pgm_pkg::FRAMES_DEF,
  parameter int unsigned PAN_STEPS = pgm_pkg::PAN_STEPS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  pgm_pkg::in_item_t               in_item_i,
  input  logic                            cfg_we_i,
  input  logic [pgm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pgm_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  pgm_pkg::q_status_t              q_status_i,
  input  logic                            clear_busy_i,
  output logic                            push_o,
  output pgm_pkg::cmd_t                   cmd_o,
  output pgm_pkg::gain_t                  gains_o
);

  localparam int unsigned IW        = $clog2(PAN_STEPS + 1);
  localparam int unsigned GAIN_W    = pgm_pkg::GAIN_W;
  localparam int unsigned VG_W      = pgm_pkg::VG_W;
  localparam int unsigned ANGLE_DIV = 2 * PAN_STEPS;
  localparam logic [63:0] PI_Q30    = 64'd3373259426;
  localparam logic [63:0] ONE_Q30   = 64'd1073741824;
  localparam logic [31:0] FRAMES_W  = 32'(FRAMES);

  // cos(k*pi/(2*PAN_STEPS)) in Q1.14 by a series truncated after the x^20 term
  function automatic logic [GAIN_W-1:0] cos_q14(input int unsigned k);
    logic [63:0]        theta;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    theta = (64'(k) * PI_Q30) / ANGLE_DIV;
    x2    = (theta * theta) >> 30;
    term  = ONE_Q30;
    sum   = $signed(ONE_Q30);
    term  = ((term * x2) >> 30) / 2;   sum = sum - $signed(term);
    term  = ((term * x2) >> 30) / 12;  sum = sum + $signed(term);
    term  = ((term * x2) >> 30) / 30;  sum = sum - $signed(term);
    term  = ((term * x2) >> 30) / 56;  sum = sum + $signed(term);
    term  = ((term * x2) >> 30) / 90;  sum = sum - $signed(term);
    term  = ((term * x2) >> 30) / 132; sum = sum + $signed(term);
    term  = ((term * x2) >> 30) / 182; sum = sum - $signed(term);
    term  = ((term * x2) >> 30) / 240; sum = sum + $signed(term);
    term  = ((term * x2) >> 30) / 306; sum = sum - $signed(term);
    term  = ((term * x2) >> 30) / 380; sum = sum + $signed(term);
    if (sum < 0) sum = 0;
    sum = (sum + 64'sd32768) >>> 16;
    if (sum > 64'sd16384) sum = 64'sd16384;
    return GAIN_W'(sum);
  endfunction

  // gains at the reset pan of center
  localparam int unsigned      RST_PIDX = (pgm_pkg::PAN_FULL * PAN_STEPS) >> 15;
  localparam logic [GAIN_W-1:0] RST_GL  = cos_q14(RST_PIDX);
  localparam logic [GAIN_W-1:0] RST_GR  = cos_q14(PAN_STEPS - RST_PIDX);
  localparam logic [VG_W-1:0]   RST_VGL = VG_W'(pgm_pkg::VOL_UNITY * RST_GL);
  localparam logic [VG_W-1:0]   RST_VGR = VG_W'(pgm_pkg::VOL_UNITY * RST_GR);

  localparam logic signed [15:0] PAN_MAX = 16'sd16384;
  localparam logic signed [15:0] PAN_MIN = -16'sd16384;

  // constant cosine table
  logic [GAIN_W-1:0] gain_tab [PAN_STEPS+1];

  for (genvar k = 0; k <= PAN_STEPS; k++) begin : g_tab
    localparam logic [GAIN_W-1:0] G = cos_q14(k);
    assign gain_tab[k] = G;
  end

  logic [pgm_pkg::VOL_W-1:0] volume_q, volume_d;
  logic                      stereo_q, stereo_d;
  logic [GAIN_W-1:0]         gl_q, gl_d, gr_q, gr_d;
  logic [VG_W-1:0]           vgl_q, vgl_d, vgr_q, vgr_d;

  logic signed [15:0]        pan_w;
  logic [15:0]               pan_off;
  logic [31:0]               pidx_prod;
  logic [IW-1:0]             pidx;
  logic [GAIN_W-1:0]         gl_new, gr_new;
  logic [pgm_pkg::VOL_W-1:0] vol_op;
  logic [GAIN_W-1:0]         gl_op, gr_op;

  // pan write: saturate, index the table for both sides
  always_comb begin
    pan_w = $signed(cfg_wdata_i[15:0]);
    if (pan_w < PAN_MIN) begin
      pan_off = 16'd0;
    end else if (pan_w > PAN_MAX) begin
      pan_off = 16'd32768;
    end else begin
      pan_off = 16'(pan_w + PAN_MAX);
    end
    pidx_prod = 32'(pan_off) * 32'(PAN_STEPS);
    pidx      = IW'(pidx_prod >> 15);
    gl_new    = gain_tab[pidx];
    gr_new    = gain_tab[IW'(PAN_STEPS) - pidx];
  end

  // register writes; volume*gain is refolded whenever either side changes
  always_comb begin
    volume_d = volume_q;
    stereo_d = stereo_q;
    gl_d     = gl_q;
    gr_d     = gr_q;
    vol_op   = volume_q;
    gl_op    = gl_q;
    gr_op    = gr_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        pgm_pkg::CFG_VOLUME: begin
          volume_d = cfg_wdata_i[pgm_pkg::VOL_W-1:0];
          vol_op   = cfg_wdata_i[pgm_pkg::VOL_W-1:0];
        end
        pgm_pkg::CFG_PAN: begin
          gl_d  = gl_new;
          gr_d  = gr_new;
          gl_op = gl_new;
          gr_op = gr_new;
        end
        pgm_pkg::CFG_STEREO: begin
          stereo_d = cfg_wdata_i[0];
        end
        default: begin
        end
      endcase
    end
    vgl_d = VG_W'(vol_op * gl_op);
    vgr_d = VG_W'(vol_op * gr_op);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volume_q <= pgm_pkg::VOL_W'(pgm_pkg::VOL_UNITY);
      stereo_q <= 1'b1;
      gl_q     <= RST_GL;
      gr_q     <= RST_GR;
      vgl_q    <= RST_VGL;
      vgr_q    <= RST_VGR;
    end else begin
      volume_q <= volume_d;
      stereo_q <= stereo_d;
      gl_q     <= gl_d;
      gr_q     <= gr_d;
      vgl_q    <= vgl_d;
      vgr_q    <= vgr_d;
    end
  end

  assign gains_o.vg_left  = vgl_q;
  assign gains_o.vg_right = vgr_q;

  // intake: hold off during the store clear or when the queue is full
  logic accept;
  logic in_range;

  assign in_stall_o = clear_busy_i || q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_range   = 32'(in_item_i.frame_index) < FRAMES_W;

  // out-of-range accumulates are dropped here; reads always go on
  assign push_o = accept && ((in_item_i.opcode == pgm_pkg::OP_READ) || in_range);

  always_comb begin
    cmd_o.opcode       = in_item_i.opcode;
    cmd_o.in_range     = in_range;
    cmd_o.frame_index  = in_item_i.frame_index;
    cmd_o.sample_left  = in_item_i.sample_left;
    cmd_o.sample_right = stereo_q ? in_item_i.sample_right : in_item_i.sample_left;
  end

endmodule

### hdl/pgm_queue.sv
// Short command queue between front and back of the mix accumulator.
// Depends on pgm_pkg for the command and status types.
module pgm_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pgm_pkg::cmd_t      cmd_i,
  input  logic               pop_i,
  output pgm_pkg::cmd_t      cmd_o,
  output pgm_pkg::q_status_t status_o
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PW    = $clog2(DEPTH);

  pgm_pkg::cmd_t    slots [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [PW:0]      count_q, count_d;
  logic             do_push, do_pop;

  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && status_o.valid;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots[wr_ptr_q] <= cmd_i;
    end
  end

  assign cmd_o          = slots[rd_ptr_q];
  assign status_o.full  = (count_q == (PW+1)'(DEPTH));
  assign status_o.valid = (count_q != '0);

endmodule

### hdl/pgm_back.sv
// Back end: frame store, gain multiply, saturating accumulate, read/clear.
// Depends on pgm_pkg; takes commands from pgm_queue and gains from pgm_front.
module pgm_back #(
  parameter int unsigned FRAMES = pgm_pkg::FRAMES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pgm_pkg::cmd_t      cmd_i,
  input  pgm_pkg::q_status_t q_status_i,
  output logic               pop_o,
  input  pgm_pkg::gain_t     gains_i,
  output logic               clear_busy_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pgm_pkg::out_item_t out_item_o
);

  localparam int unsigned AW     = $clog2(FRAMES);
  localparam int unsigned SW     = pgm_pkg::SAMPLE_W;
  localparam int unsigned PROD_W = pgm_pkg::PROD_W;
  localparam int unsigned SUM_W  = PROD_W + 1;

  // clamp limits: 32767 and -32768 scaled by 2^28
  localparam logic signed [SUM_W-1:0] SUM_HI = {4'h0, 16'h7FFF, 28'h0};
  localparam logic signed [SUM_W-1:0] SUM_LO = {4'hF, 16'h8000, 28'h0};
  localparam logic signed [SW-1:0]    SAT_HI = 16'sh7FFF;
  localparam logic signed [SW-1:0]    SAT_LO = -16'sh8000;

  // stored + term, clamp, then divide by 2^28 toward zero
  function automatic logic signed [SW-1:0] mix_one(
    input logic signed [SW-1:0]     stored,
    input logic signed [PROD_W-1:0] term
  );
    logic signed [SUM_W-1:0] total;
    logic signed [SW-1:0]    quo;
    total = $signed({{4{stored[SW-1]}}, stored, 28'h0}) + SUM_W'(term);
    quo   = total[43:28];
    if (total > SUM_HI) begin
      quo = SAT_HI;
    end else if (total < SUM_LO) begin
      quo = SAT_LO;
    end else if (total[SUM_W-1] && (total[27:0] != '0)) begin
      quo = quo + 1'b1;
    end
    return quo;
  endfunction

  // store clear sweep after reset
  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == AW'(FRAMES - 1)) clr_busy_q <= 1'b0;
    end
  end

  assign clear_busy_o = clr_busy_q;

  // pipeline control
  logic                     b1_valid_q;
  pgm_pkg::opcode_e         b1_op_q;
  logic                     b1_range_q;
  logic [AW-1:0]            b1_addr_q;
  logic signed [PROD_W-1:0] prod_l_q, prod_r_q;
  logic                     out_valid_q;
  pgm_pkg::out_item_t       out_item_q;
  logic                     out_free, adv, pop;

  assign out_free = !out_valid_q || !out_stall_i;
  assign adv      = !b1_valid_q || (b1_op_q != pgm_pkg::OP_READ) || out_free;
  assign pop      = q_status_i.valid && adv && !clr_busy_q;
  assign pop_o    = pop;

  // issue stage: register command and products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
    end else if (adv) begin
      b1_valid_q <= pop;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      b1_op_q    <= cmd_i.opcode;
      b1_range_q <= cmd_i.in_range;
      b1_addr_q  <= AW'(cmd_i.frame_index);
      prod_l_q   <= PROD_W'($signed(cmd_i.sample_left) * $signed({1'b0, gains_i.vg_left}));
      prod_r_q   <= PROD_W'($signed(cmd_i.sample_right) * $signed({1'b0, gains_i.vg_right}));
    end
  end

  // frame store with registered read
  logic signed [SW-1:0] left_mem  [FRAMES];
  logic signed [SW-1:0] right_mem [FRAMES];
  logic signed [SW-1:0] rd_left_q, rd_right_q;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic signed [SW-1:0] wr_left, wr_right;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      left_mem[wr_addr]  <= wr_left;
      right_mem[wr_addr] <= wr_right;
    end
    if (pop) begin
      rd_left_q  <= left_mem[AW'(cmd_i.frame_index)];
      rd_right_q <= right_mem[AW'(cmd_i.frame_index)];
    end
  end

  // last write, forwarded when its frame matches the issue stage
  logic                 lw_valid_q;
  logic [AW-1:0]        lw_addr_q;
  logic signed [SW-1:0] lw_left_q, lw_right_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_valid_q <= 1'b0;
    end else if (wr_en) begin
      lw_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      lw_addr_q  <= wr_addr;
      lw_left_q  <= wr_left;
      lw_right_q <= wr_right;
    end
  end

  // execute stage: merge, accumulate or clear
  logic                 fwd;
  logic signed [SW-1:0] cur_l, cur_r;
  logic signed [SW-1:0] mix_l, mix_r;

  always_comb begin
    fwd   = lw_valid_q && (lw_addr_q == b1_addr_q);
    cur_l = fwd ? lw_left_q  : rd_left_q;
    cur_r = fwd ? lw_right_q : rd_right_q;
    mix_l = mix_one(cur_l, prod_l_q);
    mix_r = mix_one(cur_r, prod_r_q);
  end

  always_comb begin
    if (clr_busy_q) begin
      wr_en    = 1'b1;
      wr_addr  = clr_addr_q;
      wr_left  = '0;
      wr_right = '0;
    end else begin
      wr_en   = b1_valid_q && adv && b1_range_q;
      wr_addr = b1_addr_q;
      if (b1_op_q == pgm_pkg::OP_READ) begin
        wr_left  = '0;
        wr_right = '0;
      end else begin
        wr_left  = mix_l;
        wr_right = mix_r;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= b1_valid_q && (b1_op_q == pgm_pkg::OP_READ);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && b1_valid_q && (b1_op_q == pgm_pkg::OP_READ)) begin
      out_item_q.sum_left  <= b1_range_q ? cur_l : '0;
      out_item_q.sum_right <= b1_range_q ? cur_r : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

### hdl/pan_gain_mix_accumulator_top.sv
// Top level of the pan/gain mix accumulator: front, command queue and back.
// Depends on pgm_pkg, pgm_front, pgm_queue and pgm_back.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------
//   input    | in_valid_i / in_stall_o   | in_item_i  (pgm_pkg::in_item_t)
//   output   | out_valid_o / out_stall_i | out_item_o (pgm_pkg::out_item_t)
//   config   | cfg_we_i                  | cfg_index_i, cfg_wdata_i
//
// One item per cycle sustained while no full queue, store clear or out_stall_i
// holds the flow; a read result passes the queue, the registered store read and
// issue stage, then the result register. After reset the store is zeroed one
// frame per cycle with in_stall_o high; config writes are taken throughout.
// The four-entry queue fills while out_stall_i holds a read result back.
module pan_gain_mix_accumulator_top #(
  parameter int unsigned FRAMES    = pgm_pkg::FRAMES_DEF,
  parameter int unsigned PAN_STEPS = pgm_pkg::PAN_STEPS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  pgm_pkg::in_item_t              in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output pgm_pkg::out_item_t             out_item_o,
  input  logic                           cfg_we_i,
  input  logic [pgm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pgm_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  pgm_pkg::cmd_t      push_cmd, head_cmd;
  pgm_pkg::q_status_t q_status;
  pgm_pkg::gain_t     gains;
  logic               push, pop, clear_busy;

  pgm_front #(
    .FRAMES    (FRAMES),
    .PAN_STEPS (PAN_STEPS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .q_status_i   (q_status),
    .clear_busy_i (clear_busy),
    .push_o       (push),
    .cmd_o        (push_cmd),
    .gains_o      (gains)
  );

  pgm_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (push_cmd),
    .pop_i    (pop),
    .cmd_o    (head_cmd),
    .status_o (q_status)
  );

  pgm_back #(
    .FRAMES (FRAMES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (head_cmd),
    .q_status_i   (q_status),
    .pop_o        (pop),
    .gains_i      (gains),
    .clear_busy_o (clear_busy),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule

### dv/pgm_checker.sv
// Checker for the pan/gain mix accumulator: tracks register writes, predicts
// every read result and compares it with what leaves the output channel.
// Depends on pgm_pkg only.
module pgm_checker #(
  parameter int unsigned FRAMES    = pgm_pkg::FRAMES_DEF,
  parameter int unsigned PAN_STEPS = pgm_pkg::PAN_STEPS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  pgm_pkg::in_item_t              in_item_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  pgm_pkg::out_item_t             out_item_i,
  input  logic                           cfg_we_i,
  input  logic [pgm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pgm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output int                             fail_count_o,
  output int                             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import pgm_pkg::*;

  localparam int FRAC_BITS = 28;
  localparam longint SAT_HI = 64'sd32767 <<< FRAC_BITS;
  localparam longint SAT_LO = -(64'sd32768 <<< FRAC_BITS);

  // shadow of the block's registers and mix store
  logic [14:0]        gain_lut [0:PAN_STEPS];
  logic signed [15:0] left_mem [FRAMES];
  logic signed [15:0] right_mem [FRAMES];
  logic [15:0]        volume_q;
  logic signed [15:0] pan_q;
  logic               stereo_q;
  out_item_t          frames_due [$];

  // cos(k * pi / (2 * PAN_STEPS)) in Q1.14 via a series truncated after the x^20 term
  function automatic logic [14:0] cos_q14(int unsigned k);
    longint unsigned theta, x2, term, n;
    longint sum;
    theta = (64'(k) * 64'd3373259426) / (64'd2 * 64'(PAN_STEPS));
    x2    = (theta * theta) >> 30;
    term  = 64'd1 << 30;
    sum   = 64'sd1 <<< 30;
    for (n = 1; n <= 10; n++) begin
      term = ((term * x2) >> 30) / ((2 * n - 1) * (2 * n));
      if (n[0]) sum -= longint'(term);
      else      sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    sum = (sum + 32768) >>> 16;
    if (sum > 16384) sum = 16384;
    return sum[14:0];
  endfunction

  initial begin
    for (int unsigned k = 0; k <= PAN_STEPS; k++) gain_lut[k] = cos_q14(k);
  end

  // exact add of sample * volume * gain, clamp, truncate toward zero
  function automatic logic signed [15:0] mix_sample(logic signed [15:0] held,
                                                     longint smp, longint gain);
    longint acc;
    acc = longint'(held) * (64'sd1 <<< FRAC_BITS)
        + smp * longint'({48'd0, volume_q}) * gain;
    if (acc > SAT_HI) acc = SAT_HI;
    if (acc < SAT_LO) acc = SAT_LO;
    acc = acc / (64'sd1 <<< FRAC_BITS);
    return acc[15:0];
  endfunction

  // effect of one accepted transaction on the store and the expected results
  task automatic mix_track_item(input in_item_t it);
    out_item_t   rd;
    int          p;
    int unsigned step;
    longint      smp_l, smp_r, g_l, g_r;
    if (it.opcode == OP_READ) begin
      rd = '0;
      if (it.frame_index < FRAMES) begin
        rd.sum_left  = left_mem[it.frame_index];
        rd.sum_right = right_mem[it.frame_index];
        left_mem[it.frame_index]  = '0;
        right_mem[it.frame_index] = '0;
      end
      frames_due.push_back(rd);
      return;
    end
    if (it.frame_index >= FRAMES) return;
    // out-of-range pan saturates before the table lookup
    p = int'(pan_q);
    if (p < -16384) p = -16384;
    if (p > 16384)  p = 16384;
    step = ((p + 16384) * PAN_STEPS) >> 15;
    if (step > PAN_STEPS) step = PAN_STEPS;
    g_l   = longint'(gain_lut[step]);
    g_r   = longint'(gain_lut[PAN_STEPS - step]);
    smp_l = longint'(it.sample_left);
    smp_r = stereo_q ? longint'(it.sample_right) : smp_l;
    left_mem[it.frame_index]  = mix_sample(left_mem[it.frame_index], smp_l, g_l);
    right_mem[it.frame_index] = mix_sample(right_mem[it.frame_index], smp_r, g_r);
  endtask

  // inputs only change at the rising edge, so the falling edge sees what the
  // next rising edge will take
  always @(negedge clk_i) begin
    out_item_t want;
    if (!rst_ni) begin
      for (int i = 0; i < FRAMES; i++) begin
        left_mem[i]  = '0;
        right_mem[i] = '0;
      end
      volume_q = 16'd16384;
      pan_q    = '0;
      stereo_q = 1'b1;
      frames_due.delete();
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_VOLUME: volume_q = cfg_wdata_i;
          CFG_PAN:    pan_q    = cfg_wdata_i;
          CFG_STEREO: stereo_q = cfg_wdata_i[0];
          default: ;
        endcase
      end
      // result transaction against the oldest expectation
      if (out_valid_i && !out_stall_i) begin
        if (frames_due.size() == 0) begin
          $error("unexpected result: sum_left %0d, sum_right %0d",
                 out_item_i.sum_left, out_item_i.sum_right);
          fail_count_o++;
        end else begin
          want = frames_due.pop_front();
          if (out_item_i.sum_left !== want.sum_left) begin
            $error("sum_left: expected %0d, actual %0d",
                   want.sum_left, out_item_i.sum_left);
            fail_count_o++;
          end
          if (out_item_i.sum_right !== want.sum_right) begin
            $error("sum_right: expected %0d, actual %0d",
                   want.sum_right, out_item_i.sum_right);
            fail_count_o++;
          end
        end
      end
      // input transaction
      if (in_valid_i && !in_stall_i) mix_track_item(in_item_i);
    end
    pending_o = frames_due.size();
  end

endmodule

### dv/testbench.sv
// Top of the pan/gain mix accumulator testbench: clock, reset, register
// writes and transaction stimulus under varying idle and stall pressure.
// Depends on pgm_pkg, pgm_checker and the block's RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pgm_pkg::*;

  localparam int BLOCKS     = 8;
  localparam int BLOCK_LEN  = 100;
  localparam int DRAIN_WAIT = 16;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_VOLUME;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int                    fail_count;
  int                    pending;
  int                    idle_pct = 0;
  int                    stall_pct = 0;

  always #5 clk = ~clk;

  pan_gain_mix_accumulator_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  pgm_checker mix_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // receiver back-pressure
  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // one register write; the enable is dropped again before the task returns
  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // one input transaction, with random idle cycles ahead of it
  task automatic send_item(input opcode_e op, input int frame,
                           input logic [15:0] s_l, input logic [15:0] s_r);
    in_item_t it;
    it.opcode       = op;
    it.frame_index  = frame[IDX_W-1:0];
    it.sample_left  = s_l;
    it.sample_right = s_r;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
  endtask

  // drop valid, let all reads come back and the accumulate pipe drain
  task automatic drain_mixer();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // sample mix weighted toward the rails and small values
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'($urandom_range(0, 15) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int base;
    int frame;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset gains, saturation, clear on read, truncation
    send_item(OP_READ, 0, 16'h0000, 16'h0000);
    send_item(OP_ACCUM, 0, 16'h7fff, 16'h8000);
    send_item(OP_ACCUM, 0, 16'h7fff, 16'h8000);
    send_item(OP_READ, 0, 16'h0000, 16'h0000);
    send_item(OP_READ, 0, 16'hffff, 16'hffff);
    send_item(OP_ACCUM, 4095, 16'hffff, 16'h0001);
    send_item(OP_READ, 4095, 16'h0000, 16'h0000);
    drain_mixer();

    // mono, max volume, pan beyond full left
    write_reg(CFG_VOLUME, 16'hffff);
    write_reg(CFG_PAN, 16'h8000);
    write_reg(CFG_STEREO, 16'h0000);
    send_item(OP_ACCUM, 1, 16'h8000, 16'h7fff);
    send_item(OP_ACCUM, 2, 16'h3039, 16'h8000);
    send_item(OP_ACCUM, 2, 16'h3039, 16'h0000);
    send_item(OP_READ, 1, 16'h0000, 16'h0000);
    send_item(OP_READ, 2, 16'h0000, 16'h0000);
    drain_mixer();

    // stereo, pan beyond full right, then exact full right and left
    write_reg(CFG_STEREO, 16'h0001);
    write_reg(CFG_PAN, 16'h7fff);
    send_item(OP_ACCUM, 3, 16'h7fff, 16'h8000);
    send_item(OP_READ, 3, 16'h0000, 16'h0000);
    drain_mixer();
    write_reg(CFG_PAN, 16'h4000);
    write_reg(CFG_VOLUME, 16'h0000);
    send_item(OP_ACCUM, 4, 16'h7fff, 16'h7fff);
    send_item(OP_READ, 4, 16'h0000, 16'h0000);
    drain_mixer();
    write_reg(CFG_PAN, 16'hc000);
    write_reg(CFG_VOLUME, 16'h4000);
    send_item(OP_ACCUM, 5, 16'h8000, 16'h7fff);
    send_item(OP_ACCUM, 5, 16'hfff0, 16'h000f);
    send_item(OP_READ, 5, 16'h0000, 16'h0000);
    drain_mixer();

    // random blocks: clustered frames so sums build up before being read
    for (int blk = 0; blk < BLOCKS; blk++) begin
      case (blk / 2)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      case (blk)
        0:       write_reg(CFG_VOLUME, 16'hffff);
        1:       write_reg(CFG_VOLUME, 16'h0000);
        2:       write_reg(CFG_VOLUME, 16'h4000);
        default: write_reg(CFG_VOLUME, 16'($urandom));
      endcase
      case (blk)
        0:       write_reg(CFG_PAN, 16'hc000);
        1:       write_reg(CFG_PAN, 16'h4000);
        2:       write_reg(CFG_PAN, 16'h7fff);
        3:       write_reg(CFG_PAN, 16'h8000);
        6:       write_reg(CFG_PAN, 16'($urandom));
        default: write_reg(CFG_PAN, 16'($urandom_range(0, 40000) - 20000));
      endcase
      write_reg(CFG_STEREO, {15'd0, blk[0]});
      base = $urandom_range(0, 4095 - 15);
      for (int n = 0; n < BLOCK_LEN; n++) begin
        frame = ($urandom_range(19) == 0) ? $urandom_range(0, 4095)
                                          : base + $urandom_range(0, 15);
        if ($urandom_range(9) < 3) send_item(OP_READ, frame, 16'($urandom), 16'($urandom));
        else                       send_item(OP_ACCUM, frame, pick_sample(), pick_sample());
        // the second half of each odd block runs with no idling and no stalling
        if (n == BLOCK_LEN / 2 && blk[0]) begin
          idle_pct  = 0;
          stall_pct = 0;
        end
      end
      drain_mixer();
    end

    stall_pct = 0;
    drain_mixer();
    if (fail_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #20ms;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
